// File: src/pfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, codes and helpers of the pixel format converter pipeline.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int PIXEL_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int SUM_W       = CHAN_W + 2;

    // floor(x / 3) == (x * 683) >> 11 for every x up to 3 * 255
    localparam int             DIV3_MUL_W = 11;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 11'd683;
    localparam int             DIV3_SHIFT = 11;

    typedef enum logic [1:0] {
        FMT_RGB888 = 2'd0,
        FMT_RGB565 = 2'd1,
        FMT_GRAY   = 2'd2,
        FMT_BINARY = 2'd3
    } fmt_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_FORMAT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_FORMAT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BINARY_THRESHOLD = 2'd2;

    localparam fmt_t              SOURCE_FORMAT_RESET    = FMT_RGB888;
    localparam fmt_t              TARGET_FORMAT_RESET    = FMT_RGB565;
    localparam logic [CHAN_W-1:0] BINARY_THRESHOLD_RESET = 8'd127;

    localparam logic [CHAN_W-1:0] BINARY_WHITE = 8'hFF;

    typedef struct packed {
        fmt_t              source_format;
        fmt_t              target_format;
        logic [CHAN_W-1:0] binary_threshold;
    } cfg_t;

    // payload leaving the unpack stage
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [SUM_W-1:0]   sum;
        logic               last;
    } unpack_t;

    // payload leaving the gray stage
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  gray;
        logic               last;
    } gray_t;

    function automatic logic [PIXEL_W-1:0] fmt_mask(input fmt_t fmt);
        logic [PIXEL_W-1:0] mask;
        unique case (fmt)
            FMT_RGB888: mask = 24'hFFFFFF;
            FMT_RGB565: mask = 24'h00FFFF;
            FMT_GRAY:   mask = 24'h0000FF;
            FMT_BINARY: mask = 24'h0000FF;
            default:    mask = 24'h0000FF;
        endcase
        return mask;
    endfunction

endpackage

// File: src/pfc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_stream_if
// Valid/ready pixel channels into and out of the converter.
// ----------------------------------------------------------------------------
interface pfc_in_if;
    import pfc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_in;
    logic               last_in;

    modport source (output valid, output pixel_in, output last_in, input ready);
    modport sink   (input valid, input pixel_in, input last_in, output ready);
endinterface

interface pfc_out_if;
    import pfc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_out;
    logic               last_out;

    modport source (output valid, output pixel_out, output last_out, input ready);
    modport sink   (input valid, input pixel_out, input last_out, output ready);
endinterface

// File: src/pfc_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_unpack
// First stage: masks the source pixel, expands it to 8-bit channels and sums
// the channels for the gray level.
// ----------------------------------------------------------------------------
module pfc_unpack (
    input  logic            clk,
    input  logic            rst_n,
    input  pfc_pkg::cfg_t   cfg,
    pfc_in_if.sink          in_stream,
    output logic            out_valid,
    output pfc_pkg::unpack_t out_data,
    input  logic            out_ready
);
    import pfc_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    unpack_t            data_reg;
    unpack_t            data_next;
    logic               advance;
    logic [PIXEL_W-1:0] pixel;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  level;

    assign advance         = !valid_reg || out_ready;
    assign in_stream.ready = advance;

    always_comb
    begin
        pixel = in_stream.pixel_in & fmt_mask(cfg.source_format);
        level = (pixel[CHAN_W-1:0] == BINARY_WHITE) ? BINARY_WHITE : '0;
        unique case (cfg.source_format)
            FMT_RGB888:
            begin
                red   = pixel[23:16];
                green = pixel[15:8];
                blue  = pixel[7:0];
            end
            FMT_RGB565:
            begin
                red   = {pixel[15:11], 3'b000};
                green = {pixel[10:5], 2'b00};
                blue  = {pixel[4:0], 3'b000};
            end
            FMT_GRAY:
            begin
                red   = pixel[CHAN_W-1:0];
                green = pixel[CHAN_W-1:0];
                blue  = pixel[CHAN_W-1:0];
            end
            default:
            begin
                red   = level;
                green = level;
                blue  = level;
            end
        endcase

        data_next.pixel = pixel;
        data_next.red   = red;
        data_next.green = green;
        data_next.blue  = blue;
        data_next.sum   = {2'b00, red} + {2'b00, green} + {2'b00, blue};
        data_next.last  = in_stream.last_in;
    end

    assign valid_next = advance ? in_stream.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_stream.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/pfc_gray.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_gray
// Second stage: gray level as the channel sum divided by three, done as a
// multiply by a reciprocal; a gray source passes its own level.
// ----------------------------------------------------------------------------
module pfc_gray (
    input  logic             clk,
    input  logic             rst_n,
    input  pfc_pkg::cfg_t    cfg,
    input  logic             in_valid,
    input  pfc_pkg::unpack_t in_data,
    output logic             in_ready,
    output logic             out_valid,
    output pfc_pkg::gray_t   out_data,
    input  logic             out_ready
);
    import pfc_pkg::*;

    localparam int PROD_W = SUM_W + DIV3_MUL_W;

    logic               valid_reg;
    logic               valid_next;
    gray_t              data_reg;
    gray_t              data_next;
    logic               advance;
    logic [PROD_W-1:0]  product;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        product = {{DIV3_MUL_W{1'b0}}, in_data.sum} * {{SUM_W{1'b0}}, DIV3_MUL};

        data_next.pixel = in_data.pixel;
        data_next.red   = in_data.red;
        data_next.green = in_data.green;
        data_next.blue  = in_data.blue;
        data_next.last  = in_data.last;
        // a gray source is already its own level
        if (cfg.source_format == FMT_GRAY)
        begin
            data_next.gray = in_data.pixel[CHAN_W-1:0];
        end
        else
        begin
            data_next.gray = product[DIV3_SHIFT +: CHAN_W];
        end
    end

    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/pfc_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pack
// Last stage: packs the channels or gray level into the target format (or
// passes the pixel when formats match) and holds it in the output register.
// ----------------------------------------------------------------------------
module pfc_pack (
    input  logic           clk,
    input  logic           rst_n,
    input  pfc_pkg::cfg_t  cfg,
    input  logic           in_valid,
    input  pfc_pkg::gray_t in_data,
    output logic           in_ready,
    pfc_out_if.source      out_stream
);
    import pfc_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [PIXEL_W-1:0] pixel_reg;
    logic [PIXEL_W-1:0] pixel_next;
    logic               last_reg;
    logic               advance;

    assign advance  = !valid_reg || out_stream.ready;
    assign in_ready = advance;

    always_comb
    begin
        if (cfg.source_format == cfg.target_format)
        begin
            pixel_next = in_data.pixel;
        end
        else if (cfg.source_format == FMT_BINARY)
        begin
            pixel_next = (in_data.pixel[CHAN_W-1:0] == BINARY_WHITE) ?
                         fmt_mask(cfg.target_format) : '0;
        end
        else
        begin
            unique case (cfg.target_format)
                FMT_RGB888:
                    pixel_next = {in_data.red, in_data.green, in_data.blue};
                FMT_RGB565:
                    pixel_next = {8'h00, in_data.red[7:3], in_data.green[7:2],
                                  in_data.blue[7:3]};
                FMT_GRAY:
                    pixel_next = {16'h0000, in_data.gray};
                default:
                    pixel_next = (in_data.gray > cfg.binary_threshold) ?
                                 {16'h0000, BINARY_WHITE} : '0;
            endcase
        end
    end

    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            pixel_reg <= pixel_next;
            last_reg  <= in_data.last;
        end
    end

    assign out_stream.valid     = valid_reg;
    assign out_stream.pixel_out = pixel_reg;
    assign out_stream.last_out  = last_reg;

endmodule

// File: src/pixel_format_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_converter
// Streaming converter between RGB888, RGB565, 8-bit gray and binary pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one converted pixel per clock while the
// output is taken. Each pixel passes three register stages (unpack and channel
// sum, divide by three by reciprocal multiply, pack into the output register).
// Under backpressure every stage holds its pixel and input ready drops only
// while the output register is full and not taken. Formats and threshold are
// plain registers written via cfg_we/cfg_index/cfg_data; change them only while
// no pixel is in flight.
module pixel_format_converter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]      cfg_data,
    pfc_in_if.sink                              in_stream,
    pfc_out_if.source                           out_stream
);
    import pfc_pkg::*;

    fmt_t              source_format_reg;
    fmt_t              target_format_reg;
    logic [CHAN_W-1:0] binary_threshold_reg;
    cfg_t              cfg;

    logic              s1_valid;
    unpack_t           s1_data;
    logic              s1_ready;
    logic              s2_valid;
    gray_t             s2_data;
    logic              s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg    <= SOURCE_FORMAT_RESET;
            target_format_reg    <= TARGET_FORMAT_RESET;
            binary_threshold_reg <= BINARY_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOURCE_FORMAT:    source_format_reg    <= fmt_t'(cfg_data[1:0]);
                CFG_TARGET_FORMAT:    target_format_reg    <= fmt_t'(cfg_data[1:0]);
                CFG_BINARY_THRESHOLD: binary_threshold_reg <= cfg_data[CHAN_W-1:0];
                default:              ;
            endcase
        end
    end

    assign cfg.source_format    = source_format_reg;
    assign cfg.target_format    = target_format_reg;
    assign cfg.binary_threshold = binary_threshold_reg;

    pfc_unpack u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_stream (in_stream),
        .out_valid (s1_valid),
        .out_data  (s1_data),
        .out_ready (s1_ready)
    );

    pfc_gray u_gray (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .in_ready  (s1_ready),
        .out_valid (s2_valid),
        .out_data  (s2_data),
        .out_ready (s2_ready)
    );

    pfc_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s2_valid),
        .in_data    (s2_data),
        .in_ready   (s2_ready),
        .out_stream (out_stream)
    );

endmodule

// File: src/pfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks of the pixel format converter, bound to the top level.
// ----------------------------------------------------------------------------
module pfc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_we,
    input logic [pfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [pfc_pkg::PIXEL_W-1:0]     pixel_out,
    input logic                            last_out
);
    import pfc_pkg::*;

    logic [2:0] occupancy_reg;
    logic [2:0] occupancy_next;
    fmt_t       target_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        occupancy_next = occupancy_reg;
        if (in_fire && !out_fire)
        begin
            occupancy_next = occupancy_reg + 3'd1;
        end
        else if (out_fire && !in_fire)
        begin
            occupancy_next = occupancy_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
            target_reg    <= TARGET_FORMAT_RESET;
        end
        else
        begin
            occupancy_reg <= occupancy_next;
            if (cfg_we && cfg_index == CFG_TARGET_FORMAT)
            begin
                target_reg <= fmt_t'(cfg_data[1:0]);
            end
        end
    end

    // three stages hold at most three pixels
    a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy_reg <= 3'd3)
        else $error("more pixels in flight than pipeline stages");

    // a result never appears without a pixel behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy_reg != 3'd0)
        else $error("output valid with no pixel in flight");

    // input stalls only behind a full, blocked output register
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output can move");

    // narrow targets keep the upper pixel bits clear
    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target_reg != FMT_RGB888 |-> pixel_out[23:16] == 8'h00 &&
        (target_reg == FMT_RGB565 || pixel_out[15:8] == 8'h00))
        else $error("bits above target width set");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(last_out))
        else $error("stalled output transaction changed");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .pixel_out (out_stream.pixel_out),
    .last_out  (out_stream.last_out)
);

// File: test/pfc_conversion_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_conversion_check
// Watches the converter's pixel channels and config port, predicts each
// converted pixel from its own copy of the format registers and compares it
// field by field with what comes out, in order.
// ----------------------------------------------------------------------------
module pfc_conversion_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    pfc_in_if                               in_mon,
    pfc_out_if                              out_mon,
    output int                              failures,
    output int                              pending
);
    import pfc_pkg::*;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               last;
    } conv_pixel_t;

    conv_pixel_t       expected_pixels[$];
    fmt_t              src_fmt;
    fmt_t              dst_fmt;
    logic [CHAN_W-1:0] threshold;

    function automatic logic [PIXEL_W-1:0] width_of(input fmt_t fmt);
        case (fmt)
            FMT_RGB888: return 24'hFFFFFF;
            FMT_RGB565: return 24'h00FFFF;
            default:    return 24'h0000FF;
        endcase
    endfunction

    function automatic logic [PIXEL_W-1:0] convert_pixel(input fmt_t src, input fmt_t dst,
                                                          input logic [CHAN_W-1:0] thr,
                                                          input logic [PIXEL_W-1:0] raw);
        logic [PIXEL_W-1:0] p;
        logic [CHAN_W-1:0]  r;
        logic [CHAN_W-1:0]  g;
        logic [CHAN_W-1:0]  b;
        logic [CHAN_W-1:0]  gray;
        logic [SUM_W-1:0]   sum;
        logic [PIXEL_W-1:0] res;
        p = raw & width_of(src);
        if (src == dst)
            return p;
        // binary source: only exact white counts
        if (src == FMT_BINARY)
            return (p[7:0] == BINARY_WHITE) ? width_of(dst) : '0;
        case (src)
            FMT_RGB888: {r, g, b} = p;
            FMT_RGB565:
            begin
                r = {p[15:11], 3'b000};
                g = {p[10:5], 2'b00};
                b = {p[4:0], 3'b000};
            end
            default:
            begin
                r = p[7:0];
                g = p[7:0];
                b = p[7:0];
            end
        endcase
        sum  = r + g + b;
        gray = (src == FMT_GRAY) ? p[7:0] : CHAN_W'(sum / 3);
        case (dst)
            FMT_RGB888: res = {r, g, b};
            FMT_RGB565: res = {8'h00, r[7:3], g[7:2], b[7:3]};
            FMT_GRAY:   res = {16'h0000, gray};
            default:    res = (gray > thr) ? 24'h0000FF : 24'h000000;
        endcase
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [PIXEL_W-1:0] want,
                                 input logic [PIXEL_W-1:0] got);
        failures++;
        if (failures <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        conv_pixel_t want;
        if (!rst_n)
        begin
            src_fmt   = SOURCE_FORMAT_RESET;
            dst_fmt   = TARGET_FORMAT_RESET;
            threshold = BINARY_THRESHOLD_RESET;
            expected_pixels.delete();
            failures  = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: unexpected output transaction, pixel %h last %b",
                                 $realtime, out_mon.pixel_out, out_mon.last_out);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_mon.pixel_out !== want.pixel)
                        note_mismatch("pixel_out", want.pixel, out_mon.pixel_out);
                    if (out_mon.last_out !== want.last)
                        note_mismatch("last_out", PIXEL_W'(want.last),
                                      PIXEL_W'(out_mon.last_out));
                end
            end
            if (in_mon.valid && in_mon.ready)
                expected_pixels.push_back({convert_pixel(src_fmt, dst_fmt, threshold,
                                                         in_mon.pixel_in), in_mon.last_in});
            if (cfg_we)
            begin
                // writes are masked to register width, unknown index ignored
                case (cfg_index)
                    CFG_SOURCE_FORMAT:    src_fmt   = fmt_t'(cfg_data[1:0]);
                    CFG_TARGET_FORMAT:    dst_fmt   = fmt_t'(cfg_data[1:0]);
                    CFG_BINARY_THRESHOLD: threshold = cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// File: test/pixel_format_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_converter_tb
// Drives directed and random pixels through every pair of formats and several
// thresholds, with idle and stall phases and a long output hold-off, while
// pfc_conversion_check predicts and compares every output transaction.
// ----------------------------------------------------------------------------
module pixel_format_converter_tb;
    import pfc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int pending_count;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    pfc_in_if  in_ch ();
    pfc_out_if out_ch ();

    pixel_format_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_stream  (in_ch),
        .out_stream (out_ch)
    );

    pfc_conversion_check conv_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .failures  (fail_count),
        .pending   (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("pixel_format_converter_tb: FAIL");
        $finish;
    end

    // output side: random stalls, or a counted hold-off when one is requested
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // sender goes quiet so nothing new enters while draining
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // upper data bits are junk on purpose, the block keeps only the low two
    task automatic set_formats(input fmt_t src, input fmt_t dst, input logic [7:0] thr);
        wait_drained();
        write_reg(CFG_SOURCE_FORMAT, {6'($urandom_range(63)), 2'(src)});
        write_reg(CFG_TARGET_FORMAT, {6'($urandom_range(63)), 2'(dst)});
        write_reg(CFG_BINARY_THRESHOLD, thr);
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.pixel_in <= pix;
        in_ch.last_in  <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [PIXEL_W-1:0] random_pixel(input fmt_t src);
        logic [PIXEL_W-1:0] p;
        logic [PIXEL_W-1:0] noise;
        case (src)
            FMT_RGB888: p = PIXEL_W'($urandom);
            FMT_RGB565: p = PIXEL_W'($urandom_range(16'hFFFF));
            FMT_GRAY:   p = PIXEL_W'($urandom_range(255));
            default:
            begin
                case ($urandom_range(3))
                    0, 1:    p = 24'h0000FF;
                    2:       p = 24'h000000;
                    default: p = PIXEL_W'($urandom_range(255));
                endcase
            end
        endcase
        // now and then junk above the format's width
        if ($urandom_range(7) == 0)
        begin
            noise = PIXEL_W'($urandom);
            case (src)
                FMT_RGB565:          p[23:16] = noise[23:16];
                FMT_GRAY, FMT_BINARY: p[23:8] = noise[23:8];
                default: ;
            endcase
        end
        return p;
    endfunction

    function automatic logic [7:0] pick_threshold();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        fmt_t src;
        fmt_t dst;
        int   mode;
        in_ch.valid    = 1'b0;
        in_ch.pixel_in = '0;
        in_ch.last_in  = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset formats: rgb888 to rgb565
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h123456, 1'b1);

        set_formats(FMT_RGB565, FMT_RGB888, 8'd127);
        send_pixel(24'h00FFFF, 1'b0);
        send_pixel(24'hFF0000, 1'b0);
        send_pixel(24'hAB07E0, 1'b1);

        set_formats(FMT_GRAY, FMT_RGB565, 8'd127);
        send_pixel(24'h0000FF, 1'b0);
        send_pixel(24'h012380, 1'b0);

        // binary in: only exact white expands, stray bits dropped first
        set_formats(FMT_BINARY, FMT_RGB888, 8'd127);
        send_pixel(24'h0000FF, 1'b0);
        send_pixel(24'h0000FE, 1'b0);
        send_pixel(24'h0001FF, 1'b1);

        set_formats(FMT_BINARY, FMT_BINARY, 8'd127);
        send_pixel(24'h00005A, 1'b0);
        send_pixel(24'hFFFF5A, 1'b0);

        // threshold is strictly greater
        set_formats(FMT_RGB888, FMT_BINARY, 8'd0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h010000, 1'b0);
        send_pixel(24'h030000, 1'b1);
        set_formats(FMT_RGB888, FMT_BINARY, 8'd255);
        send_pixel(24'hFFFFFF, 1'b0);
        set_formats(FMT_RGB888, FMT_BINARY, 8'd254);
        send_pixel(24'hFFFFFF, 1'b0);

        set_formats(FMT_RGB888, FMT_GRAY, 8'd127);
        write_reg(CFG_UNUSED_INDEX, 8'hFF);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h010101, 1'b1);

        for (int seg = 0; seg < 32; seg++)
        begin
            src = fmt_t'(seg[3:2]);
            dst = fmt_t'(seg[1:0]);
            set_formats(src, dst, pick_threshold());
            mode = (seg + seg / 4) % 4;
            case (mode)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            // long output hold-off so the pipeline fills and input backs up
            if (seg % 8 == 5)
            begin
                @(posedge clk);
                hold_cycles = 150 + $urandom_range(100);
                @(negedge clk);
            end
            repeat (33)
                send_pixel(random_pixel(src), ($urandom_range(7) == 0));
        end

        in_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("pixel_format_converter_tb: PASS");
        else
            $display("pixel_format_converter_tb: FAIL");
        $finish;
    end

endmodule
